// File: rtl/lbps_pkg.sv
`default_nettype none

package lbps_pkg;

   // Sizing
   localparam int CHANNELS = 16;
   localparam int PHASES   = 4;

   // Fixed widths of the beat fields
   localparam int CHAN_FIELD_W  = 4;
   localparam int SLOT_FIELD_W  = 2;
   localparam int TIME_W        = 32;
   localparam int DUR_W         = 16;
   localparam int REPS_W        = 8;
   localparam int TOTAL_W       = 3;

   // Derived index widths
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PH_W  = (PHASES > 1) ? $clog2(PHASES) : 1;
   localparam int EFF_W = $clog2(PHASES + 1);
   localparam int PAT_AW = CH_W + PH_W;
   localparam int PAT_DEPTH = 2 ** PAT_AW;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   // Per-channel run state held in the channel memory
   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] last_ms;
      logic [REPS_W-1:0] done;
   } chan_state_type;

   // One pattern phase held in the pattern memory
   typedef struct packed {
      logic [DUR_W-1:0]  low_ms;
      logic [DUR_W-1:0]  high_ms;
      logic [REPS_W-1:0] reps;
   } phase_entry_type;

   // Result of one tick update
   typedef struct packed {
      chan_state_type  st;
      logic [PH_W-1:0] ptr;
      logic            changed;
   } upd_type;

   localparam int CHAN_ST_W = $bits(chan_state_type);
   localparam int ENTRY_W   = $bits(phase_entry_type);

endpackage

`default_nettype wire

// File: rtl/led_blink_pattern_sequencer.sv
`default_nettype none

// Multi-channel LED blink sequencer.
// Request beats (req_*) either load one pattern phase of a channel
// (req_func = load) or tick a channel with the current millisecond time
// (req_func = tick). A load gives no response; a tick gives one response
// beat (rsp_*) with the channel, its pin level after the tick and whether
// the tick toggled it.
// A tick goes through the update stage, then into the response register.
// Throughput: one beat per cycle for loads and for ticks of different
// channels while the response is not stalled. A tick of the same channel
// as the tick just before it waits until the channel memory write is done.
// Channel state (level, toggle time, repeats done) lives in a RAM with a
// valid bit per channel; the pattern phases live in a second RAM addressed
// by channel and phase. Phase pointers and phase counts are flops.
// Reset clears the valid bits, pointers and in-flight beats and sets every
// phase count to one; no clearing pass is needed. Pattern phases are
// undefined until loaded.
// When rsp_stall is high the response holds and one more tick can sit in
// the update stage; after that req_stall rises until the response drains.
module led_blink_pattern_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_func,
   input  wire logic [lbps_pkg::CHAN_FIELD_W-1:0]   req_channel,
   input  wire logic [lbps_pkg::SLOT_FIELD_W-1:0]   req_phase_slot,
   input  wire logic [lbps_pkg::DUR_W-1:0]          req_low_time_ms,
   input  wire logic [lbps_pkg::DUR_W-1:0]          req_high_time_ms,
   input  wire logic [lbps_pkg::REPS_W-1:0]         req_repeat_count,
   input  wire logic [lbps_pkg::TOTAL_W-1:0]        req_phases_in_use,
   input  wire logic [lbps_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [lbps_pkg::CHAN_FIELD_W-1:0]   rsp_out_channel,
   output logic                                     rsp_pin_level,
   output logic                                     rsp_level_changed
);

   localparam int CH_W = lbps_pkg::CH_W;
   localparam int PH_W = lbps_pkg::PH_W;

   // Request decode
   logic            accept;
   logic            ch_ok;
   logic            slot_ok;
   logic            is_tick;
   logic            do_load;
   logic            do_tick;
   logic [CH_W-1:0] ch_idx;
   logic [PH_W-1:0] slot_idx;

   // Update stage
   logic                        s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0]             s1_ch_ff;
   logic [lbps_pkg::TIME_W-1:0] s1_now_ff;
   logic [PH_W-1:0]             s1_ptr_ff;
   logic                        s1_cs_valid_ff;
   logic                        s1_done;
   logic                        out_free;

   // Per-channel flops
   logic [PH_W-1:0]              ptr_ff     [lbps_pkg::CHANNELS];
   logic [lbps_pkg::TOTAL_W-1:0] total_ff   [lbps_pkg::CHANNELS];
   logic [lbps_pkg::CHANNELS-1:0] cs_valid_ff;

   // Memory ports
   logic [lbps_pkg::CHAN_ST_W-1:0] chan_rd_data;
   logic [lbps_pkg::ENTRY_W-1:0]   pat_rd_data;
   lbps_pkg::chan_state_type       cur_state;
   lbps_pkg::phase_entry_type      cur_entry;
   lbps_pkg::phase_entry_type      load_entry;
   lbps_pkg::upd_type              upd;

   // Response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lbps_pkg::CHAN_FIELD_W-1:0] rsp_channel_ff;
   logic                              rsp_level_ff;
   logic                              rsp_changed_ff;

   assign is_tick  = (req_func == lbps_pkg::FUNC_TICK);
   assign ch_idx   = CH_W'(req_channel);
   assign slot_idx = PH_W'(req_phase_slot);
   assign ch_ok    = (32'(req_channel) < lbps_pkg::CHANNELS);
   assign slot_ok  = (32'(req_phase_slot) < lbps_pkg::PHASES);

   // Stall while the update stage cannot drain, or on a same-channel tick
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_done   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff &&
                      (!out_free || (is_tick && (ch_idx == s1_ch_ff)));
   assign accept    = req_valid && !req_stall;
   assign do_load   = accept && !is_tick && ch_ok && slot_ok;
   assign do_tick   = accept && is_tick && ch_ok;

   assign load_entry.low_ms  = req_low_time_ms;
   assign load_entry.high_ms = req_high_time_ms;
   assign load_entry.reps    = req_repeat_count;

   lbps_ram #(
      .WIDTH (lbps_pkg::ENTRY_W),
      .DEPTH (lbps_pkg::PAT_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr ({ch_idx, slot_idx}),
      .wr_data (load_entry),
      .rd_en   (do_tick),
      .rd_addr ({ch_idx, ptr_ff[ch_idx]}),
      .rd_data (pat_rd_data)
   );

   lbps_ram #(
      .WIDTH (lbps_pkg::CHAN_ST_W),
      .DEPTH (lbps_pkg::CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (s1_ch_ff),
      .wr_data (upd.st),
      .rd_en   (do_tick),
      .rd_addr (ch_idx),
      .rd_data (chan_rd_data)
   );

   // A channel never written reads as its reset state
   assign cur_state = s1_cs_valid_ff ? lbps_pkg::chan_state_type'(chan_rd_data) : '0;
   assign cur_entry = lbps_pkg::phase_entry_type'(pat_rd_data);

   lbps_chan_update u_update (
      .cur    (cur_state),
      .ent    (cur_entry),
      .now_ms (s1_now_ff),
      .ptr    (s1_ptr_ff),
      .total  (total_ff[s1_ch_ff]),
      .upd    (upd)
   );

   // Update stage control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (do_tick) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_tick) begin
         s1_ch_ff       <= ch_idx;
         s1_now_ff      <= req_now_ms;
         s1_ptr_ff      <= ptr_ff[ch_idx];
         s1_cs_valid_ff <= cs_valid_ff[ch_idx];
      end
   end

   // Per-channel pointer, phase count and state-valid flops
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_valid_ff <= '0;
         for (int i = 0; i < lbps_pkg::CHANNELS; i++) begin
            ptr_ff[i]   <= '0;
            total_ff[i] <= lbps_pkg::TOTAL_W'(1);
         end
      end else begin
         if (s1_done) begin
            ptr_ff[s1_ch_ff]      <= upd.ptr;
            cs_valid_ff[s1_ch_ff] <= 1'b1;
         end
         if (do_load) begin
            total_ff[ch_idx] <= req_phases_in_use;
         end
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done) begin
         rsp_channel_ff <= lbps_pkg::CHAN_FIELD_W'(s1_ch_ff);
         rsp_level_ff   <= upd.st.level;
         rsp_changed_ff <= upd.changed;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_channel_ff;
   assign rsp_pin_level     = rsp_level_ff;
   assign rsp_level_changed = rsp_changed_ff;

endmodule

`default_nettype wire

// File: rtl/lbps_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module lbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/lbps_chan_update.sv
`default_nettype none

// Tick update: compare elapsed time, toggle, count repeats, advance phase
module lbps_chan_update (
   input  wire lbps_pkg::chan_state_type              cur,
   input  wire lbps_pkg::phase_entry_type             ent,
   input  wire logic [lbps_pkg::TIME_W-1:0]           now_ms,
   input  wire logic [lbps_pkg::PH_W-1:0]             ptr,
   input  wire logic [lbps_pkg::TOTAL_W-1:0]          total,
   output lbps_pkg::upd_type                          upd
);

   logic [lbps_pkg::TIME_W-1:0] elapsed;
   logic [lbps_pkg::REPS_W-1:0] done_inc;
   logic [lbps_pkg::REPS_W-1:0] reps_eff;
   logic [lbps_pkg::EFF_W-1:0]  total_eff;
   logic [lbps_pkg::EFF_W-1:0]  ptr_inc;
   logic                        low_done;
   logic                        high_done;
   logic                        advance;

   assign elapsed   = now_ms - cur.last_ms;
   assign low_done  = elapsed >= lbps_pkg::TIME_W'(ent.low_ms);
   assign high_done = elapsed >= lbps_pkg::TIME_W'(ent.high_ms);
   assign done_inc  = cur.done + lbps_pkg::REPS_W'(1);
   assign reps_eff  = (ent.reps == '0) ? lbps_pkg::REPS_W'(1) : ent.reps;
   assign advance   = (done_inc >= reps_eff) || (done_inc == '0);
   assign ptr_inc   = lbps_pkg::EFF_W'(ptr) + lbps_pkg::EFF_W'(1);

   // zero phases acts as one, too many acts as the maximum
   always_comb begin
      if (total == '0) begin
         total_eff = lbps_pkg::EFF_W'(1);
      end else if (32'(total) > lbps_pkg::PHASES) begin
         total_eff = lbps_pkg::EFF_W'(lbps_pkg::PHASES);
      end else begin
         total_eff = lbps_pkg::EFF_W'(total);
      end
   end

   always_comb begin
      upd.st      = cur;
      upd.ptr     = ptr;
      upd.changed = 1'b0;
      if (!cur.level) begin
         if (low_done) begin
            upd.st.level   = 1'b1;
            upd.st.last_ms = now_ms;
            upd.changed    = 1'b1;
         end
      end else if (high_done) begin
         upd.st.level   = 1'b0;
         upd.st.last_ms = now_ms;
         upd.changed    = 1'b1;
         upd.st.done    = done_inc;
         if (advance) begin
            upd.st.done = '0;
            upd.ptr     = (ptr_inc >= total_eff) ? '0 : lbps_pkg::PH_W'(ptr_inc);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/lbps_checker.sv
`default_nettype none

// Port-level checks for the blink sequencer
module lbps_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              req_func,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [lbps_pkg::CHAN_FIELD_W-1:0] rsp_out_channel,
   input wire logic                              rsp_pin_level,
   input wire logic                              rsp_level_changed
);

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_channel) &&
      $stable(rsp_pin_level) && $stable(rsp_level_changed))
      else $error("stalled response beat changed");

   // Nothing in flight right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or stall after reset");

   // Request stall means a tick is pending; with the response side open it must come out
   a_stall_drains: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> rsp_valid)
      else $error("pending tick did not reach the response");

   // A load is held back only by response backpressure
   a_load_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall && (req_func == lbps_pkg::FUNC_LOAD) |->
      rsp_valid && rsp_stall)
      else $error("load stalled without backpressure");

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_channel   (rsp_out_channel),
   .rsp_pin_level     (rsp_pin_level),
   .rsp_level_changed (rsp_level_changed)
);

`default_nettype wire
